// ----- design/rau_pkg.sv -----
package rau_pkg;

  localparam int unsigned KindW = 3;

  // Operation codes
  localparam logic [KindW-1:0] KIND_ADD = 3'd0;
  localparam logic [KindW-1:0] KIND_SUB = 3'd1;
  localparam logic [KindW-1:0] KIND_MUL = 3'd2;
  localparam logic [KindW-1:0] KIND_DIV = 3'd3;
  localparam logic [KindW-1:0] KIND_CMP = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [61:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic               div_by_zero;
  } rsp_t;

  // Control between sequencer and the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

// ----- design/rau_mul.sv -----
// Registered signed 34x34 multiplier, shared for all products.
module rau_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  // Register product
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ----- design/rau_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::div_req_t req_i,
  output rau_pkg::div_rsp_t rsp_o
);

  logic [63:0] quot_q, quot_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem_q[63:0], quot_q[63]};
  assign diff    = shifted - {1'b0, dvs_q};

  // Load operands on start, else advance one step of shift and subtract
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[64]) begin
        rem_d  = diff;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[63:0];

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_rem_lt_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dvs_q != 64'd0) |-> (rem_q < {1'b0, dvs_q}))
    else $error("remainder not below divisor");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("divider did not start");
`endif

endmodule

// ----- design/rational_arith_unit.sv -----
// Channel   Ports                       Handshake
// command   start_i, busy_o, req_i      taken when start_i && !busy_o
// result    res_valid_o, rsp_o          one-cycle strobe, cannot be stalled
//
// Arithmetic items with a nonzero result run each Euclid step and then the two
// final divisions on the single 64-bit restoring divider (one quotient bit a
// cycle); products use one registered multiplier. Compare items pass the
// multiply states and S_COMB to S_OUT; divide by zero and unused kinds go from
// S_M1 straight to S_OUT. Reset clears the sequencer; busy_o stays high from
// acceptance through the result strobe, and the receiver cannot stall.
module rational_arith_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rau_pkg::req_t  req_i,
  output logic           res_valid_o,
  output rau_pkg::rsp_t  rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_COMB, S_GCD, S_GWAIT,
    S_DNUM, S_WNUM, S_DDEN, S_WDEN, S_OUT
  } state_e;

  state_e state_q;
  rau_pkg::req_t r_q;
  logic signed [33:0] an_q, ad_q, bn_q, bd_q;
  logic signed [67:0] p1_q, p2_q;
  logic signed [67:0] prod;
  logic signed [33:0] mul_a, mul_b;
  logic [63:0] mag_q, den_q, g_q, h_q;
  logic        neg_q;
  rau_pkg::rsp_t rsp_q;
  logic        valid_q;
  rau_pkg::div_req_t dreq;
  rau_pkg::div_rsp_t drsp;

  logic signed [33:0] an_n, ad_n, bn_n, bd_n;
  logic signed [67:0] sp, sq;
  logic [67:0] mp, mq;

  // Normalize signs of incoming operands and negate b_num for subtraction
  always_comb begin
    an_n = 34'(req_i.a_num);
    ad_n = 34'(req_i.a_den);
    bn_n = 34'(req_i.b_num);
    bd_n = 34'(req_i.b_den);
    if (ad_n < 0) begin
      an_n = -an_n;
      ad_n = -ad_n;
    end
    if (bd_n < 0) begin
      bn_n = -bn_n;
      bd_n = -bd_n;
    end
    if (req_i.kind == rau_pkg::KIND_SUB) bn_n = -bn_n;
  end

  // Select multiplier operands by step
  always_comb begin
    mul_a = an_q;
    mul_b = bd_q;
    unique case (state_q)
      S_M1: begin
        if (r_q.kind == rau_pkg::KIND_MUL) begin
          mul_a = an_q;
          mul_b = bn_q;
        end else begin
          mul_a = an_q;
          mul_b = bd_q;
        end
      end
      S_M2: begin
        if (r_q.kind == rau_pkg::KIND_DIV) begin
          mul_a = ad_q;
          mul_b = bn_q;
        end else if (r_q.kind == rau_pkg::KIND_MUL) begin
          mul_a = ad_q;
          mul_b = bd_q;
        end else begin
          mul_a = bn_q;
          mul_b = ad_q;
        end
      end
      S_M3: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  rau_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  assign sp = p1_q;
  assign sq = p2_q;
  assign mp = sp[67] ? 68'(-sp) : 68'(sp);
  assign mq = sq[67] ? 68'(-sq) : 68'(sq);

  // Drive divider: Euclid step, then the two final divisions
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = g_q;
    dreq.divisor  = h_q;
    unique case (state_q)
      S_GCD: dreq.start = 1'b1;
      S_DNUM: begin
        dreq.start    = 1'b1;
        dreq.dividend = mag_q;
        dreq.divisor  = g_q;
      end
      S_DDEN: begin
        dreq.start    = 1'b1;
        dreq.dividend = den_q;
        dreq.divisor  = g_q;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  rau_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Sequence the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i && !valid_q) begin
            r_q  <= req_i;
            an_q <= an_n;
            ad_q <= ad_n;
            bn_q <= bn_n;
            bd_q <= bd_n;
            rsp_q <= '{res_num: '0, res_den: 62'd1, default: 1'b0};
            state_q <= S_M1;
          end
        end
        S_M1: begin
          if (r_q.kind > rau_pkg::KIND_CMP) begin
            state_q <= S_OUT;
          end else if (r_q.kind == rau_pkg::KIND_DIV && bn_q == 34'sd0) begin
            rsp_q.div_by_zero <= 1'b1;
            state_q <= S_OUT;
          end else begin
            state_q <= S_M2;
          end
        end
        S_M2: begin
          p1_q <= prod;
          state_q <= S_M3;
        end
        S_M3: begin
          p2_q <= prod;
          state_q <= S_M4;
        end
        S_M4: begin
          den_q <= 64'(prod);
          state_q <= S_COMB;
        end
        S_COMB: begin
          state_q <= S_GCD;
          // Clear Euclid operands so the next step seeds them
          g_q <= '0;
          h_q <= '0;
          unique case (r_q.kind)
            rau_pkg::KIND_CMP: begin
              rsp_q.is_less    <= sp < sq;
              rsp_q.is_equal   <= sp == sq;
              rsp_q.is_greater <= sp > sq;
              state_q <= S_OUT;
            end
            rau_pkg::KIND_MUL: begin
              neg_q <= sp[67];
              mag_q <= 64'(mp);
              den_q <= 64'(sq);
            end
            rau_pkg::KIND_DIV: begin
              neg_q <= sp[67] ^ sq[67];
              mag_q <= 64'(mp);
              den_q <= 64'(mq);
            end
            default: begin
              if (sp[67] == sq[67]) begin
                neg_q <= sp[67];
                mag_q <= 64'(mp + mq);
              end else if (mp >= mq) begin
                neg_q <= sp[67];
                mag_q <= 64'(mp - mq);
              end else begin
                neg_q <= sq[67];
                mag_q <= 64'(mq - mp);
              end
            end
          endcase
        end
        S_GCD: begin
          // Mag zero: result 0/1; on entry seed g and h; h zero: gcd is g
          if (g_q == 64'd0 && h_q == 64'd0) begin
            if (mag_q == 64'd0) begin
              state_q <= S_OUT;
            end else begin
              g_q <= mag_q;
              h_q <= den_q;
            end
          end else if (h_q == 64'd0) begin
            state_q <= S_DNUM;
          end else begin
            state_q <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (drsp.done) begin
            g_q <= h_q;
            h_q <= drsp.rem;
            state_q <= S_GCD;
          end
        end
        S_DNUM: state_q <= S_WNUM;
        S_WNUM: begin
          if (drsp.done) begin
            rsp_q.res_num <= neg_q ? -drsp.quot : drsp.quot;
            state_q <= S_DDEN;
          end
        end
        S_DDEN: state_q <= S_WDEN;
        S_WDEN: begin
          if (drsp.done) begin
            rsp_q.res_den <= drsp.quot[61:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE) || valid_q;
  assign res_valid_o = valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> busy_o) else $error("busy low during item");
  a_one_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $onehot0({rsp_o.is_less, rsp_o.is_equal, rsp_o.is_greater}))
    else $error("more than one compare flag");
  a_strobe_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe repeated");
`endif

endmodule

// ----- test/tb_rational_arith_unit.sv -----
module tb_rational_arith_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1800;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  rau_pkg::req_t req_i = '0;
  logic res_valid_o;
  rau_pkg::rsp_t rsp_o;

  rau_pkg::req_t pending_reqs[$];
  rau_pkg::rsp_t expected_results[$];
  int unsigned errors = 0;
  int unsigned idle_left = 0;
  int unsigned quiet_cycles = 0;

  rational_arith_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .rsp_o      (rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Reduce sign and magnitude over den by Euclid's GCD
  function automatic rau_pkg::rsp_t reduced_fraction(logic neg, logic [63:0] mag,
                                                     logic [63:0] den);
    rau_pkg::rsp_t o;
    logic [63:0] g, h, t;
    o = '0;
    o.res_den = 62'd1;
    if (mag == 64'd0) return o;
    g = mag;
    h = den;
    while (h != 64'd0) begin
      t = g % h;
      g = h;
      h = t;
    end
    mag = mag / g;
    den = den / g;
    o.res_num = neg ? -mag : mag;
    o.res_den = den[61:0];
    return o;
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Exact fraction result for one item
  function automatic rau_pkg::rsp_t rational_result(rau_pkg::req_t r);
    rau_pkg::rsp_t o;
    longint an, ad, bn, bd, p, q, n, d;
    logic [63:0] mp, mq, dd;
    o = '0;
    o.res_den = 62'd1;
    an = r.a_num;
    ad = r.a_den;
    bn = r.b_num;
    bd = r.b_den;
    if (ad < 0) begin
      an = -an;
      ad = -ad;
    end
    if (bd < 0) begin
      bn = -bn;
      bd = -bd;
    end
    dd = 64'(ad) * 64'(bd);
    case (r.kind)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        if (r.kind == rau_pkg::KIND_SUB) bn = -bn;
        p = an * bd;
        q = bn * ad;
        mp = magnitude(p);
        mq = magnitude(q);
        if ((p < 0) == (q < 0)) o = reduced_fraction(p < 0, mp + mq, dd);
        else if (mp >= mq) o = reduced_fraction(p < 0, mp - mq, dd);
        else o = reduced_fraction(q < 0, mq - mp, dd);
      end
      rau_pkg::KIND_MUL: begin
        n = an * bn;
        o = reduced_fraction(n < 0, magnitude(n), dd);
      end
      rau_pkg::KIND_DIV: begin
        if (bn == 0) begin
          o.div_by_zero = 1'b1;
        end else begin
          n = an * bd;
          d = ad * bn;
          if (d < 0) begin
            n = -n;
            d = -d;
          end
          o = reduced_fraction(n < 0, magnitude(n), 64'(d));
        end
      end
      rau_pkg::KIND_CMP: begin
        p = an * bd;
        q = bn * ad;
        o.is_less = p < q;
        o.is_equal = p == q;
        o.is_greater = p > q;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic signed [31:0] operand_value();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      3, 4: return 32'($urandom_range(0, 200000)) - 32'sd100000;
      default: return 32'($urandom_range(0, 2000)) - 32'sd1000;
    endcase
  endfunction

  function automatic rau_pkg::req_t make_req(logic [rau_pkg::KindW-1:0] k, int an, int ad,
                                             int bn, int bd);
    rau_pkg::req_t r;
    r.kind = k;
    r.a_num = an;
    r.a_den = ad;
    r.b_num = bn;
    r.b_den = bd;
    return r;
  endfunction

  // Draw the gap before the next item, with idle-free stretches
  function automatic int unsigned gap_draw();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  // Drive items: hold start until taken, then idle or advance
  always @(posedge clk_i) begin
    int unsigned gap;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_results.push_back(rational_result(req_i));
        quiet_cycles <= 0;
        gap = gap_draw();
        if (gap == 0 && pending_reqs.size() > 0) begin
          req_i <= pending_reqs.pop_front();
        end else begin
          start_i <= 1'b0;
          idle_left <= gap;
        end
      end else if (!start_i) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
        end else if (pending_reqs.size() > 0) begin
          req_i <= pending_reqs.pop_front();
          start_i <= 1'b1;
        end
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    rau_pkg::rsp_t exp_rsp;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: num=%0d den=%0d", rsp_o.res_num,
               rsp_o.res_den);
        errors++;
      end else begin
        exp_rsp = expected_results.pop_front();
        if (rsp_o.res_num !== exp_rsp.res_num) begin
          $error("res_num: expected %0d, got %0d", exp_rsp.res_num, rsp_o.res_num);
          errors++;
        end
        if (rsp_o.res_den !== exp_rsp.res_den) begin
          $error("res_den: expected %0d, got %0d", exp_rsp.res_den, rsp_o.res_den);
          errors++;
        end
        if (rsp_o.is_less !== exp_rsp.is_less) begin
          $error("is_less: expected %0b, got %0b", exp_rsp.is_less, rsp_o.is_less);
          errors++;
        end
        if (rsp_o.is_equal !== exp_rsp.is_equal) begin
          $error("is_equal: expected %0b, got %0b", exp_rsp.is_equal, rsp_o.is_equal);
          errors++;
        end
        if (rsp_o.is_greater !== exp_rsp.is_greater) begin
          $error("is_greater: expected %0b, got %0b", exp_rsp.is_greater,
                 rsp_o.is_greater);
          errors++;
        end
        if (rsp_o.div_by_zero !== exp_rsp.div_by_zero) begin
          $error("div_by_zero: expected %0b, got %0b", exp_rsp.div_by_zero,
                 rsp_o.div_by_zero);
          errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && !(start_i && !busy_o)) begin
      if (quiet_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [rau_pkg::KindW-1:0] k;
    // Directed: every operation, extremes, zero denominators, divide by zero
    pending_reqs.push_back(make_req(rau_pkg::KIND_ADD, 1, 2, 1, 3));
    pending_reqs.push_back(make_req(rau_pkg::KIND_SUB, 1, 2, 1, 2));
    pending_reqs.push_back(make_req(rau_pkg::KIND_MUL, -3, 4, 2, -9));
    pending_reqs.push_back(make_req(rau_pkg::KIND_DIV, 5, -6, -10, 3));
    pending_reqs.push_back(make_req(rau_pkg::KIND_CMP, 1, 3, 2, 6));
    pending_reqs.push_back(make_req(rau_pkg::KIND_CMP, -1, 3, 1, 3));
    pending_reqs.push_back(make_req(rau_pkg::KIND_CMP, 1, -3, -1, -2));
    pending_reqs.push_back(make_req(rau_pkg::KIND_DIV, 7, 3, 0, 5));
    pending_reqs.push_back(make_req(rau_pkg::KIND_DIV, 0, 3, 0, -5));
    pending_reqs.push_back(make_req(3'd5, 1, 2, 3, 4));
    pending_reqs.push_back(make_req(3'd6, -1, -2, -3, -4));
    pending_reqs.push_back(make_req(3'd7, 32'h8000_0000, 1, 1, 1));
    pending_reqs.push_back(make_req(rau_pkg::KIND_ADD, 5, 0, 3, 7));
    pending_reqs.push_back(make_req(rau_pkg::KIND_MUL, -5, 0, 3, 0));
    pending_reqs.push_back(make_req(rau_pkg::KIND_MUL, 0, 0, 3, 0));
    pending_reqs.push_back(make_req(rau_pkg::KIND_ADD, 32'h8000_0000, 1,
                                    32'h8000_0000, 1));
    pending_reqs.push_back(make_req(rau_pkg::KIND_SUB, 32'h8000_0000, -1,
                                    32'h8000_0000, 1));
    pending_reqs.push_back(make_req(rau_pkg::KIND_MUL, 32'h8000_0000, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(rau_pkg::KIND_DIV, 32'h7fff_ffff, 32'h8000_0000,
                                    32'h8000_0000, 32'h7fff_ffff));
    pending_reqs.push_back(make_req(rau_pkg::KIND_ADD, 1, 32'h8000_0000, 1,
                                    32'h8000_0000));
    pending_reqs.push_back(make_req(rau_pkg::KIND_MUL, 1, 32'h8000_0000, 1,
                                    32'h8000_0000));
    pending_reqs.push_back(make_req(rau_pkg::KIND_CMP, 32'h8000_0000, 1,
                                    32'h7fff_ffff, 1));
    pending_reqs.push_back(make_req(rau_pkg::KIND_ADD, 0, -7, 0, 9));
    // Random items, mostly defined operations
    for (int i = 0; i < NumRandom; i++) begin
      k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                       : 3'($urandom_range(0, 4));
      pending_reqs.push_back(make_req(k, operand_value(), operand_value(), operand_value(),
                                      operand_value()));
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !start_i && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
